### rtl/ile_pkg.sv
// shared types and constants of the indexed list engine
`default_nettype none
package ile_pkg;

  localparam int CAPACITY = 32;
  localparam int IW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int PW       = 6;
  localparam int CMPW     = (CW > PW) ? CW : PW;
  localparam int VW       = 32;
  localparam int BCW      = $clog2(VW);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_READ   = 3'd2;
  localparam logic [2:0] FN_MOVE   = 3'd3;
  localparam logic [2:0] FN_REV    = 3'd4;
  localparam logic [2:0] FN_ROTL   = 3'd5;
  localparam logic [2:0] FN_ROTR   = 3'd6;

  typedef enum logic [2:0] {
    OP_INSERT, OP_REMOVE, OP_READ, OP_MOVE, OP_REV, OP_ROTL, OP_ROTR, OP_BAD
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic signed [VW-1:0] value;
    logic [PW-1:0]        p1;
    logic [PW-1:0]        p2;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/ile_if.sv
// channel interfaces for commands and results
`default_nettype none
interface ile_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic signed [31:0] value;
  logic [5:0]        first_index;
  logic [5:0]        second_index;
  modport source (output valid, func, value, first_index, second_index, input ready);
  modport sink   (input valid, func, value, first_index, second_index, output ready);
endinterface

interface ile_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] item;
  logic               last;
  modport source (output valid, status, item, last, input ready);
  modport sink   (input valid, status, item, last, output ready);
endinterface
`default_nettype wire

### rtl/ile_front.sv
// front end: takes command transfers and decodes the function code
`default_nettype none
module ile_front import ile_pkg::*; (
  ile_in_if.sink in_ch,
  input  wire logic push_ready_i,
  output cmd_t      push_cmd_o,
  output logic      push_valid_o
);

  op_e op;

  // function decode
  always_comb begin
    unique case (in_ch.func)
      FN_INSERT: op = OP_INSERT;
      FN_REMOVE: op = OP_REMOVE;
      FN_READ:   op = OP_READ;
      FN_MOVE:   op = OP_MOVE;
      FN_REV:    op = OP_REV;
      FN_ROTL:   op = OP_ROTL;
      FN_ROTR:   op = OP_ROTR;
      default:   op = OP_BAD;
    endcase
  end

  assign push_cmd_o   = '{op: op, value: in_ch.value, p1: in_ch.first_index,
                          p2: in_ch.second_index};
  assign push_valid_o = in_ch.valid;
  assign in_ch.ready  = push_ready_i;

endmodule
`default_nettype wire

### rtl/ile_fifo.sv
// two-entry command queue between front and back
`default_nettype none
module ile_fifo import ile_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      push_ready_o,
  input  wire logic pop_i,
  output cmd_t      pop_cmd_o,
  output logic      pop_valid_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_cmd_i;
  end

endmodule
`default_nettype wire

### rtl/ile_back.sv
// back end: list store, command sequencer and result register
`default_nettype none
module ile_back import ile_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  ile_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_MOD  = 7'b0000100,
    S_ROT  = 7'b0001000,
    S_REV  = 7'b0010000,
    S_READ = 7'b0100000,
    S_RESP = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {SH_NONE, SH_LEFT, SH_RIGHT} shift_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       k_q, k_d;
  logic [BCW-1:0]      bit_q, bit_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic [1:0]          stat_q, stat_d;
  logic [VW-1:0]       store_q [CAPACITY];
  logic [VW-1:0]       store_d [CAPACITY];
  logic                ovalid_q;
  logic [1:0]          ostat_q, ostat_d;
  logic [VW-1:0]       oitem_q, oitem_d;
  logic                olast_q, olast_d;
  logic                oload, ofree;
  shift_e              sh_op;
  logic [IW-1:0]       sh_a, sh_b, raddr;
  logic [VW-1:0]       sh_dat, rdata;
  logic [CMPW-1:0]     p1c, p2c, cntc;
  logic [CW:0]         mod_t;
  logic [CW-1:0]       rem_n, rot_s;
  logic [IW-1:0]       cnt_m1;

  assign ofree  = !ovalid_q || out_ch.ready;
  assign raddr  = (state_q == S_READ) ? k_q : IW'(cmd_q.p1);
  assign rdata  = store_q[raddr];
  assign p1c    = CMPW'(cmd_q.p1);
  assign p2c    = CMPW'(cmd_q.p2);
  assign cntc   = CMPW'(count_q);
  assign cnt_m1 = IW'(count_q - CW'(1));

  // serial remainder step and rotation amount
  always_comb begin
    mod_t = {rem_q, cmd_q.value[bit_q]};
    if (mod_t >= {1'b0, count_q}) mod_t = mod_t - {1'b0, count_q};
    rem_n = CW'(mod_t);
    if (cmd_q.op == OP_ROTR && rem_n != '0) rot_s = count_q - rem_n;
    else rot_s = rem_n;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    k_d     = k_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    stat_d  = stat_q;
    sh_op   = SH_NONE;
    sh_a    = '0;
    sh_b    = '0;
    sh_dat  = '0;
    q_pop_o = 1'b0;
    oload   = 1'b0;
    ostat_d = ST_OK;
    oitem_d = '0;
    olast_d = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        stat_d  = ST_OK;
        case (cmd_q.op) inside
          OP_INSERT: begin
            if (p1c > cntc) stat_d = ST_RANGE;
            else if (count_q >= CW'(CAPACITY)) stat_d = ST_FULL;
            else begin
              sh_op   = SH_RIGHT;
              sh_a    = IW'(cmd_q.p1);
              sh_b    = IW'(count_q);
              sh_dat  = cmd_q.value;
              count_d = count_q + CW'(1);
            end
          end
          OP_REMOVE: begin
            if (p1c >= cntc) stat_d = ST_RANGE;
            else begin
              sh_op   = SH_LEFT;
              sh_a    = IW'(cmd_q.p1);
              sh_b    = cnt_m1;
              count_d = count_q - CW'(1);
            end
          end
          OP_READ: begin
            if (count_q == '0) stat_d = ST_EMPTY;
            else begin
              k_d     = '0;
              state_d = S_READ;
            end
          end
          OP_MOVE: begin
            if (p1c >= cntc || p2c >= cntc) stat_d = ST_RANGE;
            else if (p1c < p2c) begin
              sh_op  = SH_LEFT;
              sh_a   = IW'(cmd_q.p1);
              sh_b   = IW'(cmd_q.p2);
              sh_dat = rdata;
            end else if (p1c > p2c) begin
              sh_op  = SH_RIGHT;
              sh_a   = IW'(cmd_q.p2);
              sh_b   = IW'(cmd_q.p1);
              sh_dat = rdata;
            end
          end
          OP_REV: begin
            if (count_q > CW'(1)) begin
              k_d     = cnt_m1;
              state_d = S_REV;
            end
          end
          OP_ROTL, OP_ROTR: begin
            if (cmd_q.value[VW-1]) stat_d = ST_RANGE;
            else if (count_q != '0) begin
              rem_d   = '0;
              bit_d   = BCW'(VW - 1);
              state_d = S_MOD;
            end
          end
          default: stat_d = ST_RANGE;
        endcase
      end
      S_MOD: begin
        rem_d = rem_n;
        if (bit_q == '0) begin
          if (rot_s == '0) state_d = S_RESP;
          else begin
            k_d     = IW'(rot_s);
            state_d = S_ROT;
          end
        end else bit_d = bit_q - BCW'(1);
      end
      S_ROT: begin
        sh_op  = SH_LEFT;
        sh_b   = cnt_m1;
        sh_dat = store_q[0];
        if (k_q == IW'(1)) state_d = S_RESP;
        else k_d = k_q - IW'(1);
      end
      S_REV: begin
        sh_op  = SH_LEFT;
        sh_b   = k_q;
        sh_dat = store_q[0];
        if (k_q == IW'(1)) state_d = S_RESP;
        else k_d = k_q - IW'(1);
      end
      S_READ: begin
        if (ofree) begin
          oload   = 1'b1;
          oitem_d = rdata;
          olast_d = (k_q == cnt_m1);
          if (k_q == cnt_m1) state_d = S_IDLE;
          else k_d = k_q + IW'(1);
        end
      end
      S_RESP: begin
        if (ofree) begin
          oload   = 1'b1;
          ostat_d = stat_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // window shift over the store, one element per entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_d[i] = store_q[i];
      if (sh_op == SH_LEFT) begin
        if (IW'(i) >= sh_a && IW'(i) < sh_b) store_d[i] = store_q[(i + 1) % CAPACITY];
        else if (IW'(i) == sh_b) store_d[i] = sh_dat;
      end else if (sh_op == SH_RIGHT) begin
        if (IW'(i) > sh_a && IW'(i) <= sh_b) store_d[i] = store_q[(i + CAPACITY - 1) % CAPACITY];
        else if (IW'(i) == sh_a) store_d[i] = sh_dat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (oload) ovalid_q <= 1'b1;
      else if (out_ch.ready) ovalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    k_q     <= k_d;
    bit_q   <= bit_d;
    rem_q   <= rem_d;
    stat_q  <= stat_d;
    store_q <= store_d;
    if (oload) begin
      ostat_q <= ostat_d;
      oitem_q <= oitem_d;
      olast_q <= olast_d;
    end
  end

  assign out_ch.valid  = ovalid_q;
  assign out_ch.status = ostat_q;
  assign out_ch.item   = oitem_q;
  assign out_ch.last   = olast_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("list count beyond capacity");
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> count_q != '0) else $error("read stream on empty list");
  a_mod_rotate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> (cmd_q.op == OP_ROTL || cmd_q.op == OP_ROTR))
    else $error("remainder unit busy without rotation");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == S_IDLE) else $error("command taken while busy");

endmodule
`default_nettype wire

### rtl/indexed_list_engine_core.sv
// Indexed list engine top level: ordered list of signed 32-bit values
// Channels: in_ch carries commands (func, value, first_index,
// second_index), out_ch carries results (status, item, last); a transfer
// happens when valid and ready are both high.
// A two-entry queue sits between the decoding front and the back end, so
// commands are taken while the back end works or a result waits.
// Steps from command to first result, once the back end is free:
//   insert, remove, move, bad code: take, execute, result register
//   reverse: take, execute, a series of single-place window shifts, result register
//   rotate: take, execute, serial remainder over the 32 value bits (one bit
//     per cycle), then up to count - 1 single-place shifts of the list store
//   read all: count results, one per cycle while ready stays high; last marks the final one
// One command is carried out at a time by the back end sequencer; the
// sustained command rate is set by that sequencer.
// Reset empties the list (count zero) and clears the queue and the result
// valid flag; the store contents are not cleared.
// When the receiver holds ready low the result register keeps its value,
// the back end stalls, and the queue fills then drops in_ch.ready.
`default_nettype none
module indexed_list_engine_core import ile_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ile_in_if.sink     in_ch,
  ile_out_if.source  out_ch
);

  cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop;

  // command decode
  ile_front u_front (
    .in_ch        (in_ch),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd),
    .push_valid_o (push_valid)
  );

  // decoupling queue
  ile_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd),
    .pop_valid_o  (pop_valid)
  );

  // list execution
  ile_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### bench/indexed_list_engine_core_chk.sv
// checker: watches both channels, predicts the list engine results and compares them
`default_nettype none
module indexed_list_engine_core_chk import ile_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ile_in_if         in_ch,
  ile_out_if        out_ch,
  output int        fail_count_o,
  output int        pending_o,
  output int        list_len_o
);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic               last;
  } answer_t;

  logic signed [31:0] shadow_list [CAPACITY];
  int                 shadow_len;
  answer_t            answer_q [$];

  assign pending_o  = answer_q.size();
  assign list_len_o = shadow_len;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  // append one expected answer
  function automatic void queue_answer(input answer_t a);
    answer_q = {answer_q, a};
  endfunction

  function automatic answer_t status_only(input logic [1:0] st);
    answer_t a;
    a.status = st;
    a.item   = '0;
    a.last   = 1'b1;
    return a;
  endfunction

  function automatic void list_take(input int pos);
    for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
  endfunction

  function automatic void list_put(input int pos, input logic signed [31:0] v);
    for (int i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos] = v;
    shadow_len++;
  endfunction

  // apply one command to the shadow list and queue its answers
  function automatic void predict_list_cmd(input logic [2:0] fn, input logic signed [31:0] v,
                                           input int p1, input int p2);
    logic signed [31:0] tmp [CAPACITY];
    logic signed [31:0] held;
    int                 sh;
    answer_t            a;
    case (fn) inside
      FN_INSERT: begin
        if (p1 > shadow_len) queue_answer(status_only(ST_RANGE));
        else if (shadow_len >= CAPACITY) queue_answer(status_only(ST_FULL));
        else begin
          list_put(p1, v);
          queue_answer(status_only(ST_OK));
        end
      end
      FN_REMOVE: begin
        if (p1 >= shadow_len) queue_answer(status_only(ST_RANGE));
        else begin
          list_take(p1);
          queue_answer(status_only(ST_OK));
        end
      end
      FN_READ: begin
        if (shadow_len == 0) queue_answer(status_only(ST_EMPTY));
        else for (int i = 0; i < shadow_len; i++) begin
          a.status = ST_OK;
          a.item   = shadow_list[i];
          a.last   = (i + 1 == shadow_len);
          queue_answer(a);
        end
      end
      FN_MOVE: begin
        if (p1 >= shadow_len || p2 >= shadow_len) queue_answer(status_only(ST_RANGE));
        else begin
          if (p1 != p2) begin
            held = shadow_list[p1];
            list_take(p1);
            list_put(p2, held);
          end
          queue_answer(status_only(ST_OK));
        end
      end
      FN_REV: begin
        for (int i = 0; i < shadow_len / 2; i++) begin
          held = shadow_list[i];
          shadow_list[i] = shadow_list[shadow_len-1-i];
          shadow_list[shadow_len-1-i] = held;
        end
        queue_answer(status_only(ST_OK));
      end
      FN_ROTL, FN_ROTR: begin
        if (v[31]) queue_answer(status_only(ST_RANGE));
        else begin
          if (shadow_len != 0) begin
            sh = int'({1'b0, v[30:0]} % shadow_len);
            if (sh != 0) begin
              if (fn == FN_ROTR) sh = shadow_len - sh;
              for (int i = 0; i < shadow_len; i++) tmp[i] = shadow_list[(i + sh) % shadow_len];
              for (int i = 0; i < shadow_len; i++) shadow_list[i] = tmp[i];
            end
          end
          queue_answer(status_only(ST_OK));
        end
      end
      default: queue_answer(status_only(ST_RANGE));
    endcase
  endfunction

  // sample transfers on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      shadow_len   = 0;
      fail_count_o = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_list_cmd(in_ch.func, in_ch.value, in_ch.first_index, in_ch.second_index);
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) report_mismatch("result transfer with nothing expected");
        else begin
          want = answer_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
          if (out_ch.item !== want.item)
            report_mismatch($sformatf("item %0d, expected %0d", out_ch.item, want.item));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, want.last));
        end
      end
    end
  end

endmodule
`default_nettype wire

### bench/indexed_list_engine_core_tb.sv
// testbench top: clock, reset, command stimulus, result stalls and verdict
`default_nettype none
module indexed_list_engine_core_tb import ile_pkg::*;;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, list_len;
  int   quiet_cycles = 0;
  bit   no_idle, hold_off;

  ile_in_if  in_ch ();
  ile_out_if out_ch ();

  indexed_list_engine_core dut (.clk_i, .rst_ni, .in_ch, .out_ch);

  indexed_list_engine_core_chk checker_u (
    .clk_i, .rst_ni, .in_ch, .out_ch,
    .fail_count_o(fail_count), .pending_o(pending), .list_len_o(list_len)
  );

  always #1 clk_i = ~clk_i;

  // one command transfer, with random idling before it
  task automatic send_cmd(input logic [2:0] fn, input logic signed [31:0] v,
                          input logic [5:0] p1, input logic [5:0] p2);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.value <= v;
    in_ch.first_index <= p1;
    in_ch.second_index <= p2;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_answers();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_pos(input int limit);
    if ($urandom_range(9) == 0) return 6'($urandom);
    return 6'($urandom_range(limit));
  endfunction

  // receiver side: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 12);
  end

  // watchdog on transfers
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("[indexed_list_engine_core] ERROR");
      $finish;
    end
  end

  initial begin
    logic [2:0]         fn;
    logic signed [31:0] v;
    int                 r;
    in_ch.valid = 1'b0;
    in_ch.func = FN_INSERT;
    in_ch.value = '0;
    in_ch.first_index = '0;
    in_ch.second_index = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-list corner cases, then corner cases on a short list
    send_cmd(FN_READ, 0, 0, 0);
    send_cmd(FN_REV, 0, 0, 0);
    send_cmd(FN_ROTL, 5, 0, 0);
    send_cmd(FN_ROTR, 32'sh8000_0000, 0, 0);
    send_cmd(FN_REMOVE, 0, 0, 0);
    send_cmd(FN_MOVE, 0, 0, 0);
    send_cmd(3'd7, 0, 0, 0);
    send_cmd(FN_INSERT, 1, 6'd1, 0);
    send_cmd(FN_INSERT, 32'sh7fff_ffff, 0, 0);
    send_cmd(FN_INSERT, 32'sh8000_0000, 0, 6'd63);
    send_cmd(FN_INSERT, -1, 6'd2, 0);
    send_cmd(FN_READ, 0, 0, 0);
    send_cmd(FN_MOVE, 0, 0, 6'd2);
    send_cmd(FN_MOVE, 0, 6'd1, 6'd1);
    send_cmd(FN_MOVE, 0, 6'd3, 0);
    send_cmd(FN_ROTL, 32'sh7fff_ffff, 0, 0);
    send_cmd(FN_ROTR, 3, 0, 0);
    send_cmd(FN_REV, 0, 0, 0);
    send_cmd(FN_REMOVE, 0, 6'd63, 0);
    send_cmd(FN_READ, 0, 0, 0);
    drain_answers();

    // fill to capacity, receiver held off; then one insert too many, one out of range
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      while (list_len < CAPACITY || pending > 40) begin
        send_cmd(FN_INSERT, $urandom, 6'($urandom_range(list_len)), 0);
      end
    join
    send_cmd(FN_INSERT, 7, 0, 0);
    send_cmd(FN_INSERT, 7, 6'd33, 0);
    send_cmd(FN_READ, 0, 0, 0);
    drain_answers();

    // random part, a stretch without idling in the middle
    for (int n = 0; n < 390; n++) begin
      no_idle = (n >= 130 && n < 210);
      r = $urandom_range(99);
      v = $urandom;
      if (r < 30) fn = FN_INSERT;
      else if (r < 50) fn = FN_REMOVE;
      else if (r < 60) fn = FN_READ;
      else if (r < 72) fn = FN_MOVE;
      else if (r < 78) fn = FN_REV;
      else if (r < 88) fn = FN_ROTL;
      else if (r < 98) fn = FN_ROTR;
      else fn = 3'd7;
      if ((fn == FN_ROTL || fn == FN_ROTR) && $urandom_range(3) != 0)
        v = $urandom_range(70);
      send_cmd(fn, v, pick_pos(list_len), pick_pos(list_len));
    end
    no_idle = 1'b0;
    drain_answers();
    repeat (200) @(posedge clk_i);

    if (fail_count == 0) $display("[indexed_list_engine_core] OK");
    else $display("[indexed_list_engine_core] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
